[hdl/rgbled_pkg.sv]
// ----------------------------------------------------------------------------
// RGB indicator LED controller package
// Request codes, kept-kind indexes, beat types and the fixed arithmetic
// helpers shared by the controller, the kept-state store and the testbench.
// ----------------------------------------------------------------------------
package rgbled_pkg;

    // light kind codes on the request channel
    localparam logic [2:0] FUNC_BACKLIGHT    = 3'd0;
    localparam logic [2:0] FUNC_BATTERY      = 3'd1;
    localparam logic [2:0] FUNC_NOTIFICATION = 3'd2;
    localparam logic [2:0] FUNC_ATTENTION    = 3'd3;

    // flash modes
    localparam logic [1:0] FLASH_NONE  = 2'd0;
    localparam logic [1:0] FLASH_TIMED = 2'd1;
    localparam logic [1:0] FLASH_HW    = 2'd2;

    localparam int unsigned NUM_KEPT = 3;

    localparam logic [11:0] BRIGHTNESS_RESET = 12'd255;
    localparam logic [31:0] RGB_MASK         = 32'h00ff_ffff;

    localparam logic [15:0] LUMA_R = 16'd77;
    localparam logic [15:0] LUMA_G = 16'd150;
    localparam logic [15:0] LUMA_B = 16'd29;
    localparam logic [20:0] DIV_BASE = 21'd255;

    // kept-state slots, in LED priority order
    typedef enum logic [1:0] {
        KIND_NOTIF,
        KIND_ATTN,
        KIND_BATT
    } kind_t;

    typedef enum logic [1:0] {
        OP_BACKLIGHT,
        OP_KEEP,
        OP_UNSUP
    } op_t;

    // chosen kept entry, already resolved to LED times
    typedef struct packed {
        logic [7:0]  alpha;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [15:0] on_ms;
        logic [15:0] off_ms;
    } led_pick_t;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [15:0] on_ms;
        logic [15:0] off_ms;
    } led_drive_t;

    typedef struct packed {
        logic        status;
        logic        backlight_valid;
        logic [11:0] backlight_level;
        logic        led_valid;
        led_drive_t  led;
    } rsp_t;

    function automatic logic is_lit(input logic [31:0] color);
        return (color & RGB_MASK) != 32'd0;
    endfunction

    // (77R + 150G + 29B) >> 8
    function automatic logic [7:0] luma(input logic [31:0] color);
        logic [15:0] sum;
        sum = LUMA_R * 16'(color[23:16]) + LUMA_G * 16'(color[15:8])
            + LUMA_B * 16'(color[7:0]);
        return sum[15:8];
    endfunction

    // floor(x / 255), exact for x up to 255 * 255
    function automatic logic [7:0] div255_u16(input logic [15:0] x);
        logic [16:0] t;
        t = 17'(x) + 17'(x[15:8]) + 17'd1;
        return t[15:8];
    endfunction

    // floor(x / 255) for x below 255 * 4096: estimate low by at most one, then fix up
    function automatic logic [11:0] div255_u20(input logic [19:0] x);
        logic [20:0] s;
        logic [12:0] q;
        logic [20:0] r;
        s = 21'(x) + 21'(x[19:8]) + 21'(x[19:16]);
        q = s[20:8];
        r = 21'(x) - ((21'(q) << 8) - 21'(q));
        if (r >= DIV_BASE)
        begin
            q = q + 13'd1;
        end
        return q[11:0];
    endfunction

endpackage

[hdl/rgbled_if.sv]
// ----------------------------------------------------------------------------
// RGB indicator LED controller channels
// Valid/ready channels for light requests, results and the brightness
// register write.
// ----------------------------------------------------------------------------
interface rgbled_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  func;
    logic [31:0] argb_color;
    logic [1:0]  flash_mode;
    logic [15:0] on_time_ms;
    logic [15:0] off_time_ms;

    modport source (output valid, func, argb_color, flash_mode, on_time_ms, off_time_ms,
                    input ready);
    modport sink   (input valid, func, argb_color, flash_mode, on_time_ms, off_time_ms,
                    output ready);
    modport mon    (input valid, ready, func, argb_color, flash_mode, on_time_ms,
                    off_time_ms);
endinterface

interface rgbled_rsp_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic        backlight_valid;
    logic [11:0] backlight_level;
    logic        led_valid;
    logic [7:0]  led_red;
    logic [7:0]  led_green;
    logic [7:0]  led_blue;
    logic [15:0] led_on_ms;
    logic [15:0] led_off_ms;

    modport source (output valid, status, backlight_valid, backlight_level, led_valid,
                    led_red, led_green, led_blue, led_on_ms, led_off_ms,
                    input ready);
    modport sink   (input valid, status, backlight_valid, backlight_level, led_valid,
                    led_red, led_green, led_blue, led_on_ms, led_off_ms,
                    output ready);
    modport mon    (input valid, ready, status, backlight_valid, backlight_level,
                    led_valid, led_red, led_green, led_blue, led_on_ms, led_off_ms);
endinterface

interface rgbled_cfg_if;
    logic        valid;
    logic        ready;
    logic [11:0] max_panel_brightness;

    modport source (output valid, max_panel_brightness, input ready);
    modport sink   (input valid, max_panel_brightness, output ready);
    modport mon    (input valid, ready, max_panel_brightness);
endinterface

[hdl/rgbled_kept.sv]
// ----------------------------------------------------------------------------
// RGB indicator LED kept-state store
// Holds the last notification, attention and battery request and picks the
// first lit one, seeing the request in the input stage as already written.
// ----------------------------------------------------------------------------
module rgbled_kept #(
    parameter int unsigned TW = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  upd,
    input  logic                  commit,
    input  rgbled_pkg::kind_t     kind,
    input  logic [31:0]           color,
    input  logic [1:0]            mode,
    input  logic [15:0]           on_ms,
    input  logic [15:0]           off_ms,
    output rgbled_pkg::led_pick_t pick
);

    logic [31:0]   color_reg [0:rgbled_pkg::NUM_KEPT-1];
    logic [1:0]    mode_reg  [0:rgbled_pkg::NUM_KEPT-1];
    logic [TW-1:0] on_reg    [0:rgbled_pkg::NUM_KEPT-1];
    logic [TW-1:0] off_reg   [0:rgbled_pkg::NUM_KEPT-1];

    logic [31:0]   color_view [0:rgbled_pkg::NUM_KEPT-1];
    logic [1:0]    mode_view  [0:rgbled_pkg::NUM_KEPT-1];
    logic [TW-1:0] on_view    [0:rgbled_pkg::NUM_KEPT-1];
    logic [TW-1:0] off_view   [0:rgbled_pkg::NUM_KEPT-1];

    rgbled_pkg::kind_t sel;
    logic              any_lit;
    logic [31:0]       sel_color;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < rgbled_pkg::NUM_KEPT; i++)
            begin
                color_reg[i] <= '0;
                mode_reg[i]  <= '0;
                on_reg[i]    <= '0;
                off_reg[i]   <= '0;
            end
        end
        else if (commit)
        begin
            color_reg[kind] <= color;
            mode_reg[kind]  <= mode;
            on_reg[kind]    <= on_ms[TW-1:0];
            off_reg[kind]   <= off_ms[TW-1:0];
        end
    end

    // forward the pending write so the pick reflects this request
    always_comb
    begin
        for (int i = 0; i < rgbled_pkg::NUM_KEPT; i++)
        begin
            color_view[i] = color_reg[i];
            mode_view[i]  = mode_reg[i];
            on_view[i]    = on_reg[i];
            off_view[i]   = off_reg[i];
        end
        if (upd)
        begin
            color_view[kind] = color;
            mode_view[kind]  = mode;
            on_view[kind]    = on_ms[TW-1:0];
            off_view[kind]   = off_ms[TW-1:0];
        end
    end

    always_comb
    begin
        sel     = rgbled_pkg::KIND_NOTIF;
        any_lit = 1'b1;
        priority if (rgbled_pkg::is_lit(color_view[rgbled_pkg::KIND_NOTIF]))
        begin
            sel = rgbled_pkg::KIND_NOTIF;
        end
        else if (rgbled_pkg::is_lit(color_view[rgbled_pkg::KIND_ATTN]))
        begin
            sel = rgbled_pkg::KIND_ATTN;
        end
        else if (rgbled_pkg::is_lit(color_view[rgbled_pkg::KIND_BATT]))
        begin
            sel = rgbled_pkg::KIND_BATT;
        end
        else
        begin
            any_lit = 1'b0;
        end
    end

    assign sel_color = color_view[sel];

    always_comb
    begin
        pick = '0;
        if (any_lit)
        begin
            pick.alpha = sel_color[31:24];
            pick.red   = sel_color[23:16];
            pick.green = sel_color[15:8];
            pick.blue  = sel_color[7:0];
            unique case (mode_view[sel])
                rgbled_pkg::FLASH_NONE:
                begin
                    pick.on_ms = 16'd1;
                end
                rgbled_pkg::FLASH_TIMED, rgbled_pkg::FLASH_HW:
                begin
                    pick.on_ms  = 16'(on_view[sel]);
                    pick.off_ms = 16'(off_view[sel]);
                end
                default:
                begin
                    // undefined mode: leave both times at zero
                end
            endcase
        end
    end

endmodule

[hdl/rgb_indicator_led_controller.sv]
// ----------------------------------------------------------------------------
// RGB indicator LED controller
// Light requests in, one result beat per request out.
// ----------------------------------------------------------------------------
// Usage:
//   req  carries one light request per beat; rsp returns exactly one result
//   beat per request, in order. cfg writes the panel maximum brightness and
//   is always ready; write it only while no request is in flight.
//   A backlight request returns the luma of its colour rescaled to the
//   panel maximum. A notification, attention or battery request is kept and
//   the LED drive of the first lit kept request (notification first, then
//   attention, then battery) is returned. Other kinds return status 1.
//   A request passes the input, product, level and result registers in turn. One request
//   is taken every cycle: the four pipeline registers (input, product,
//   level, result) each pass a beat per cycle while rsp.ready is high.
//   When rsp is stalled the result register holds its beat and the stages
//   behind it keep filling; req.ready falls only once all four are full.
//   Reset empties the pipeline, clears the kept requests to unlit and sets
//   the panel maximum to 255.
// ----------------------------------------------------------------------------
module rgb_indicator_led_controller #(
    parameter int unsigned TIME_WIDTH  = 16,
    parameter int unsigned LEVEL_WIDTH = 12
) (
    input  logic         clk,
    input  logic         rst_n,
    rgbled_cfg_if.sink   cfg,
    rgbled_req_if.sink   req,
    rgbled_rsp_if.source rsp
);

    localparam int unsigned KEPT_TW  = (TIME_WIDTH < 16) ? TIME_WIDTH : 16;
    localparam int unsigned LVL_KEEP = (LEVEL_WIDTH < 12) ? LEVEL_WIDTH : 12;
    localparam logic [11:0] LVL_MASK = 12'((32'd1 << LVL_KEEP) - 32'd1);

    logic [11:0] max_bright_reg;

    // pipeline control
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic s1_valid_next, s2_valid_next, s3_valid_next, out_valid_next;
    logic s1_ready, s2_ready, s3_ready, out_ready;

    // input stage
    logic [2:0]  s1_func_reg;
    logic [31:0] s1_color_reg;
    logic [1:0]  s1_mode_reg;
    logic [15:0] s1_on_reg;
    logic [15:0] s1_off_reg;

    rgbled_pkg::op_t       s1_op;
    rgbled_pkg::kind_t     s1_kind;
    rgbled_pkg::led_pick_t pick;
    logic                  s1_keep;

    // product stage
    rgbled_pkg::op_t s2_op_reg;
    logic [7:0]      s2_luma_reg;
    logic [15:0]     s2_prod_r_reg, s2_prod_g_reg, s2_prod_b_reg;
    logic [15:0]     s2_on_reg, s2_off_reg;

    // level stage
    rgbled_pkg::op_t        s3_op_reg;
    logic [19:0]            s3_level_prod_reg;
    rgbled_pkg::led_drive_t s3_led_reg;

    rgbled_pkg::rsp_t out_reg;
    rgbled_pkg::rsp_t out_next;

    // ---------------------------------------------------------------- config
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_bright_reg <= rgbled_pkg::BRIGHTNESS_RESET;
        end
        else if (cfg.valid)
        begin
            max_bright_reg <= cfg.max_panel_brightness;
        end
    end

    // ------------------------------------------------------------ flow control
    always_comb
    begin
        out_ready      = !out_valid_reg || rsp.ready;
        s3_ready       = !s3_valid_reg || out_ready;
        s2_ready       = !s2_valid_reg || s3_ready;
        s1_ready       = !s1_valid_reg || s2_ready;
        s1_valid_next  = s1_ready ? req.valid : s1_valid_reg;
        s2_valid_next  = s2_ready ? s1_valid_reg : s2_valid_reg;
        s3_valid_next  = s3_ready ? s2_valid_reg : s3_valid_reg;
        out_valid_next = out_ready ? s3_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            s3_valid_reg  <= s3_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign req.ready = s1_ready;

    // ------------------------------------------------------------ input stage
    always_ff @(posedge clk)
    begin
        if (s1_ready && req.valid)
        begin
            s1_func_reg  <= req.func;
            s1_color_reg <= req.argb_color;
            s1_mode_reg  <= req.flash_mode;
            s1_on_reg    <= req.on_time_ms;
            s1_off_reg   <= req.off_time_ms;
        end
    end

    always_comb
    begin
        s1_op   = rgbled_pkg::OP_UNSUP;
        s1_kind = rgbled_pkg::KIND_NOTIF;
        unique case (s1_func_reg)
            rgbled_pkg::FUNC_BACKLIGHT:
            begin
                s1_op = rgbled_pkg::OP_BACKLIGHT;
            end
            rgbled_pkg::FUNC_BATTERY:
            begin
                s1_op   = rgbled_pkg::OP_KEEP;
                s1_kind = rgbled_pkg::KIND_BATT;
            end
            rgbled_pkg::FUNC_NOTIFICATION:
            begin
                s1_op   = rgbled_pkg::OP_KEEP;
                s1_kind = rgbled_pkg::KIND_NOTIF;
            end
            rgbled_pkg::FUNC_ATTENTION:
            begin
                s1_op   = rgbled_pkg::OP_KEEP;
                s1_kind = rgbled_pkg::KIND_ATTN;
            end
            default:
            begin
                s1_op = rgbled_pkg::OP_UNSUP;
            end
        endcase
    end

    assign s1_keep = s1_valid_reg && (s1_op == rgbled_pkg::OP_KEEP);

    rgbled_kept #(
        .TW (KEPT_TW)
    ) u_kept (
        .clk    (clk),
        .rst_n  (rst_n),
        .upd    (s1_keep),
        .commit (s1_keep && s2_ready),
        .kind   (s1_kind),
        .color  (s1_color_reg),
        .mode   (s1_mode_reg),
        .on_ms  (s1_on_reg),
        .off_ms (s1_off_reg),
        .pick   (pick)
    );

    // ---------------------------------------------------------- product stage
    // An alpha of 255 needs no bypass: c * 255 / 255 is c exactly.
    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_op_reg   <= s1_op;
            s2_luma_reg <= (s1_op == rgbled_pkg::OP_BACKLIGHT) ?
                           rgbled_pkg::luma(s1_color_reg) : 8'd0;
            if (s1_op == rgbled_pkg::OP_KEEP)
            begin
                s2_prod_r_reg <= 16'(pick.red) * 16'(pick.alpha);
                s2_prod_g_reg <= 16'(pick.green) * 16'(pick.alpha);
                s2_prod_b_reg <= 16'(pick.blue) * 16'(pick.alpha);
                s2_on_reg     <= pick.on_ms;
                s2_off_reg    <= pick.off_ms;
            end
            else
            begin
                s2_prod_r_reg <= '0;
                s2_prod_g_reg <= '0;
                s2_prod_b_reg <= '0;
                s2_on_reg     <= '0;
                s2_off_reg    <= '0;
            end
        end
    end

    // ------------------------------------------------------------ level stage
    // A maximum of 255 rescales to the same luma, so no bypass here either.
    always_ff @(posedge clk)
    begin
        if (s3_ready && s2_valid_reg)
        begin
            s3_op_reg         <= s2_op_reg;
            s3_level_prod_reg <= 20'(s2_luma_reg) * 20'(max_bright_reg);
            s3_led_reg.red    <= rgbled_pkg::div255_u16(s2_prod_r_reg);
            s3_led_reg.green  <= rgbled_pkg::div255_u16(s2_prod_g_reg);
            s3_led_reg.blue   <= rgbled_pkg::div255_u16(s2_prod_b_reg);
            s3_led_reg.on_ms  <= s2_on_reg;
            s3_led_reg.off_ms <= s2_off_reg;
        end
    end

    // ----------------------------------------------------------- result stage
    always_comb
    begin
        out_next                 = '0;
        out_next.status          = (s3_op_reg == rgbled_pkg::OP_UNSUP);
        out_next.backlight_valid = (s3_op_reg == rgbled_pkg::OP_BACKLIGHT);
        out_next.backlight_level = rgbled_pkg::div255_u20(s3_level_prod_reg) & LVL_MASK;
        out_next.led_valid       = (s3_op_reg == rgbled_pkg::OP_KEEP);
        out_next.led             = s3_led_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && s3_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = out_reg.status;
    assign rsp.backlight_valid = out_reg.backlight_valid;
    assign rsp.backlight_level = out_reg.backlight_level;
    assign rsp.led_valid       = out_reg.led_valid;
    assign rsp.led_red         = out_reg.led.red;
    assign rsp.led_green       = out_reg.led.green;
    assign rsp.led_blue        = out_reg.led.blue;
    assign rsp.led_on_ms       = out_reg.led.on_ms;
    assign rsp.led_off_ms      = out_reg.led.off_ms;

endmodule

[hdl/rgbled_checker.sv]
// ----------------------------------------------------------------------------
// RGB indicator LED controller checker
// Port-level assertions on the result and request channels, bound to the top level.
// ----------------------------------------------------------------------------
module rgbled_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic        rsp_status,
    input logic        rsp_backlight_valid,
    input logic [11:0] rsp_backlight_level,
    input logic        rsp_led_valid,
    input logic [7:0]  rsp_led_red,
    input logic [7:0]  rsp_led_green,
    input logic [7:0]  rsp_led_blue,
    input logic [15:0] rsp_led_on_ms,
    input logic [15:0] rsp_led_off_ms
);

    // a stalled result beat holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_backlight_valid) && $stable(rsp_backlight_level)
            && $stable(rsp_led_valid) && $stable(rsp_led_red)
            && $stable(rsp_led_green) && $stable(rsp_led_blue)
            && $stable(rsp_led_on_ms) && $stable(rsp_led_off_ms))
        else $error("result beat changed while stalled");

    // each result is exactly one of unsupported, backlight or LED
    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> $onehot({rsp_status, rsp_backlight_valid, rsp_led_valid}))
        else $error("result beat carries no single kind");

    // unsupported request: every payload field is zero
    a_unsup_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status |-> rsp_backlight_level == 12'd0
            && rsp_led_red == 8'd0 && rsp_led_green == 8'd0 && rsp_led_blue == 8'd0
            && rsp_led_on_ms == 16'd0 && rsp_led_off_ms == 16'd0)
        else $error("unsupported beat with nonzero payload");

    // backlight result leaves the LED fields clear
    a_backlight_led_clear: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_backlight_valid |-> rsp_led_red == 8'd0
            && rsp_led_green == 8'd0 && rsp_led_blue == 8'd0
            && rsp_led_on_ms == 16'd0 && rsp_led_off_ms == 16'd0)
        else $error("backlight beat with LED drive");

    // a draining result side never back-pressures requests
    a_ready_through: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_ready |-> req_ready)
        else $error("request stalled while results drain");

endmodule

bind rgb_indicator_led_controller rgbled_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .req_valid           (req.valid),
    .req_ready           (req.ready),
    .rsp_valid           (rsp.valid),
    .rsp_ready           (rsp.ready),
    .rsp_status          (rsp.status),
    .rsp_backlight_valid (rsp.backlight_valid),
    .rsp_backlight_level (rsp.backlight_level),
    .rsp_led_valid       (rsp.led_valid),
    .rsp_led_red         (rsp.led_red),
    .rsp_led_green       (rsp.led_green),
    .rsp_led_blue        (rsp.led_blue),
    .rsp_led_on_ms       (rsp.led_on_ms),
    .rsp_led_off_ms      (rsp.led_off_ms)
);

[tb/sv/tb_rgb_indicator_led_controller.sv]
// ----------------------------------------------------------------------------
// RGB indicator LED controller testbench
// Streams light requests through the controller and checks every result beat
// against a cycle-free model of the kept requests, LED priority and backlight
// scaling. The panel maximum is rewritten between phases while the pipeline
// is empty. Both channels idle in random bursts, except in quiet phases.
// ----------------------------------------------------------------------------
module tb_rgb_indicator_led_controller;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] FUNC_FIRST_UNSUPPORTED = 3'd4;
    localparam logic [2:0] FUNC_LAST              = 3'd7;
    localparam logic [1:0] FLASH_RESERVED         = 2'd3;
    localparam int         NUM_PHASES             = 8;
    localparam int         ITEMS_PER_PHASE        = 228;
    localparam int         MAX_REPORTS            = 100;

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] argb;
        logic [1:0]  flash;
        logic [15:0] on_ms;
        logic [15:0] off_ms;
    } light_req_t;

    logic clk = 1'b0;
    logic rst_n;
    logic idling_on = 1'b1;

    rgbled_cfg_if cfg_if();
    rgbled_req_if req_if();
    rgbled_rsp_if rsp_if();

    rgb_indicator_led_controller dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_if),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    light_req_t       req_backlog[$];
    rgbled_pkg::rsp_t expected_rsp[$];
    logic [11:0]      panel_writes[$];

    // mirror of the controller's kept requests and register
    logic [31:0] kept_argb [rgbled_pkg::NUM_KEPT];
    logic [1:0]  kept_flash [rgbled_pkg::NUM_KEPT];
    logic [15:0] kept_on [rgbled_pkg::NUM_KEPT];
    logic [15:0] kept_off [rgbled_pkg::NUM_KEPT];
    logic [11:0] panel_max;

    int errors = 0;
    int n_backlight = 0;
    int n_kept = 0;
    int n_unsupported = 0;
    int n_results = 0;
    int n_settings = 0;
    int gap_left;
    int stall_left;

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic rgbled_pkg::rsp_t predict_light(input light_req_t rq);
        rgbled_pkg::rsp_t  res;
        int unsigned       level;
        int unsigned       alpha;
        int unsigned       red;
        int unsigned       grn;
        int unsigned       blu;
        rgbled_pkg::kind_t slot;
        int                idx;
        int                pick;
        logic [31:0]       c;
        res = '0;
        if (rq.func == rgbled_pkg::FUNC_BACKLIGHT)
        begin
            level = (77 * int'(rq.argb[23:16]) + 150 * int'(rq.argb[15:8])
                     + 29 * int'(rq.argb[7:0])) >> 8;
            if (panel_max != rgbled_pkg::BRIGHTNESS_RESET)
            begin
                level = level * int'(panel_max) / 255;
            end
            res.backlight_valid = 1'b1;
            res.backlight_level = level[11:0];
            return res;
        end
        case (rq.func)
            rgbled_pkg::FUNC_BATTERY:      slot = rgbled_pkg::KIND_BATT;
            rgbled_pkg::FUNC_NOTIFICATION: slot = rgbled_pkg::KIND_NOTIF;
            rgbled_pkg::FUNC_ATTENTION:    slot = rgbled_pkg::KIND_ATTN;
            default:
            begin
                res.status = 1'b1;
                return res;
            end
        endcase
        kept_argb[slot]  = rq.argb;
        kept_flash[slot] = rq.flash;
        kept_on[slot]    = rq.on_ms;
        kept_off[slot]   = rq.off_ms;
        res.led_valid = 1'b1;
        // slots are indexed in priority order: take the first lit one
        pick = -1;
        for (idx = 0; idx < rgbled_pkg::NUM_KEPT; idx++)
        begin
            if (pick < 0 && kept_argb[idx][23:0] != 24'd0)
            begin
                pick = idx;
            end
        end
        if (pick < 0)
        begin
            return res;
        end
        c = kept_argb[pick];
        alpha = 32'(c[31:24]);
        red = 32'(c[23:16]);
        grn = 32'(c[15:8]);
        blu = 32'(c[7:0]);
        if (alpha != 255)
        begin
            red = red * alpha / 255;
            grn = grn * alpha / 255;
            blu = blu * alpha / 255;
        end
        res.led.red   = red[7:0];
        res.led.green = grn[7:0];
        res.led.blue  = blu[7:0];
        case (kept_flash[pick])
            rgbled_pkg::FLASH_TIMED, rgbled_pkg::FLASH_HW:
            begin
                res.led.on_ms  = kept_on[pick];
                res.led.off_ms = kept_off[pick];
            end
            rgbled_pkg::FLASH_NONE: res.led.on_ms = 16'd1;
            default: ;
        endcase
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
            begin
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, name, want, got);
            end
            if (errors == MAX_REPORTS)
            begin
                $display("%0t: further mismatches not shown", $time);
            end
        end
    endtask

    // request driver: hold a beat until taken, then idle or advance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_if.valid       <= 1'b0;
            req_if.func        <= '0;
            req_if.argb_color  <= '0;
            req_if.flash_mode  <= '0;
            req_if.on_time_ms  <= '0;
            req_if.off_time_ms <= '0;
            gap_left           <= 0;
        end
        else if (!req_if.valid || req_if.ready)
        begin
            if (gap_left != 0)
            begin
                req_if.valid <= 1'b0;
                gap_left     <= gap_left - 1;
            end
            else if (idling_on && $urandom_range(0, 11) == 0)
            begin
                req_if.valid <= 1'b0;
                gap_left     <= $urandom_range(0, 13);
            end
            else if (req_backlog.size() != 0)
            begin
                light_req_t nxt;
                nxt = req_backlog.pop_front();
                req_if.valid       <= 1'b1;
                req_if.func        <= nxt.func;
                req_if.argb_color  <= nxt.argb;
                req_if.flash_mode  <= nxt.flash;
                req_if.on_time_ms  <= nxt.on_ms;
                req_if.off_time_ms <= nxt.off_ms;
            end
            else
            begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // result sink: stall in random bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            stall_left   <= 0;
        end
        else if (stall_left != 0)
        begin
            rsp_if.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
        else if (idling_on && $urandom_range(0, 9) == 0)
        begin
            rsp_if.ready <= 1'b0;
            stall_left   <= $urandom_range(0, 13);
        end
        else
        begin
            rsp_if.ready <= 1'b1;
        end
    end

    // brightness register writer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_if.valid                <= 1'b0;
            cfg_if.max_panel_brightness <= '0;
        end
        else if (!cfg_if.valid || cfg_if.ready)
        begin
            if (panel_writes.size() != 0)
            begin
                cfg_if.valid                <= 1'b1;
                cfg_if.max_panel_brightness <= panel_writes.pop_front();
            end
            else
            begin
                cfg_if.valid <= 1'b0;
            end
        end
    end

    // monitor: predict on each request beat, then check each result beat
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < rgbled_pkg::NUM_KEPT; k++)
            begin
                kept_argb[k]  = '0;
                kept_flash[k] = '0;
                kept_on[k]    = '0;
                kept_off[k]   = '0;
            end
            panel_max = rgbled_pkg::BRIGHTNESS_RESET;
            expected_rsp.delete();
        end
        else
        begin
            if (cfg_if.valid && cfg_if.ready)
            begin
                panel_max = cfg_if.max_panel_brightness;
            end
            if (req_if.valid && req_if.ready)
            begin
                light_req_t       taken;
                rgbled_pkg::rsp_t guess;
                taken.func   = req_if.func;
                taken.argb   = req_if.argb_color;
                taken.flash  = req_if.flash_mode;
                taken.on_ms  = req_if.on_time_ms;
                taken.off_ms = req_if.off_time_ms;
                if (taken.func == rgbled_pkg::FUNC_BACKLIGHT)
                begin
                    n_backlight++;
                end
                else if (taken.func >= FUNC_FIRST_UNSUPPORTED)
                begin
                    n_unsupported++;
                end
                else
                begin
                    n_kept++;
                end
                guess = predict_light(taken);
                expected_rsp = {expected_rsp, guess};
            end
            if (rsp_if.valid && rsp_if.ready)
            begin
                rgbled_pkg::rsp_t want;
                n_results++;
                if (expected_rsp.size() == 0)
                begin
                    errors++;
                    $display("%0t: result beat with nothing expected, status %0b",
                             $time, rsp_if.status);
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    check_field("status", 32'(want.status), 32'(rsp_if.status));
                    check_field("backlight_valid", 32'(want.backlight_valid),
                                32'(rsp_if.backlight_valid));
                    check_field("backlight_level", 32'(want.backlight_level),
                                32'(rsp_if.backlight_level));
                    check_field("led_valid", 32'(want.led_valid), 32'(rsp_if.led_valid));
                    check_field("led_red", 32'(want.led.red), 32'(rsp_if.led_red));
                    check_field("led_green", 32'(want.led.green), 32'(rsp_if.led_green));
                    check_field("led_blue", 32'(want.led.blue), 32'(rsp_if.led_blue));
                    check_field("led_on_ms", 32'(want.led.on_ms), 32'(rsp_if.led_on_ms));
                    check_field("led_off_ms", 32'(want.led.off_ms),
                                32'(rsp_if.led_off_ms));
                end
            end
        end
    end

    task automatic post_request(input logic [2:0] func, input logic [31:0] argb,
                                input logic [1:0] flash, input logic [15:0] on_ms,
                                input logic [15:0] off_ms);
        light_req_t rq;
        rq.func   = func;
        rq.argb   = argb;
        rq.flash  = flash;
        rq.on_ms  = on_ms;
        rq.off_ms = off_ms;
        req_backlog = {req_backlog, rq};
    endtask

    function automatic light_req_t random_request();
        light_req_t rq;
        int         sel;
        sel = $urandom_range(0, 99);
        if (sel < 20)
        begin
            rq.func = rgbled_pkg::FUNC_BACKLIGHT;
        end
        else if (sel < 30)
        begin
            rq.func = 3'($urandom_range(FUNC_FIRST_UNSUPPORTED, FUNC_LAST));
        end
        else
        begin
            rq.func = 3'($urandom_range(rgbled_pkg::FUNC_BATTERY,
                                        rgbled_pkg::FUNC_ATTENTION));
        end
        rq.argb = $urandom();
        // unlit colours make the priority fall through
        if ($urandom_range(0, 3) == 0)
        begin
            rq.argb[23:0] = '0;
        end
        sel = $urandom_range(0, 9);
        if (sel < 3)
        begin
            rq.argb[31:24] = 8'hff;
        end
        else if (sel == 3)
        begin
            rq.argb[31:24] = 8'h00;
        end
        rq.flash = ($urandom_range(0, 9) == 0) ? FLASH_RESERVED : 2'($urandom_range(0, 2));
        rq.on_ms  = ($urandom_range(0, 7) == 0) ? 16'hffff : 16'($urandom());
        rq.off_ms = ($urandom_range(0, 7) == 0) ? 16'h0000 : 16'($urandom());
        return rq;
    endfunction

    task automatic wait_until_idle();
        @(negedge clk);
        while (req_backlog.size() != 0 || req_if.valid || expected_rsp.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic set_panel_max(input logic [11:0] value);
        wait_until_idle();
        panel_writes = {panel_writes, value};
        @(negedge clk);
        while (panel_writes.size() != 0 || cfg_if.valid)
        begin
            @(negedge clk);
        end
        n_settings++;
    endtask

    initial
    begin
        logic [11:0] settings [NUM_PHASES];
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: luma extremes, unsupported kinds, priority and flash cases
        post_request(rgbled_pkg::FUNC_BACKLIGHT, 32'h0000_0000, rgbled_pkg::FLASH_NONE,
                     16'h0000, 16'h0000);
        post_request(rgbled_pkg::FUNC_BACKLIGHT, 32'hffff_ffff, FLASH_RESERVED,
                     16'hffff, 16'hffff);
        post_request(rgbled_pkg::FUNC_BACKLIGHT, 32'h12ff_0000, rgbled_pkg::FLASH_NONE,
                     16'h0001, 16'h0000);
        post_request(rgbled_pkg::FUNC_BACKLIGHT, 32'h0000_ff00, rgbled_pkg::FLASH_TIMED,
                     16'h0000, 16'h0001);
        post_request(rgbled_pkg::FUNC_BACKLIGHT, 32'hff00_00ff, rgbled_pkg::FLASH_HW,
                     16'h1234, 16'h4321);
        for (int f = FUNC_FIRST_UNSUPPORTED; f <= FUNC_LAST; f++)
        begin
            post_request(3'(f), $urandom(), 2'($urandom_range(0, 3)), 16'hffff, 16'hffff);
        end
        post_request(rgbled_pkg::FUNC_BATTERY, 32'h80ff_8040, rgbled_pkg::FLASH_NONE,
                     16'h0000, 16'h0000);
        post_request(rgbled_pkg::FUNC_ATTENTION, 32'hff00_ff00, rgbled_pkg::FLASH_TIMED,
                     16'hffff, 16'h0000);
        post_request(rgbled_pkg::FUNC_NOTIFICATION, 32'h00ff_ffff, rgbled_pkg::FLASH_HW,
                     16'h0000, 16'hffff);
        post_request(rgbled_pkg::FUNC_NOTIFICATION, 32'hffff_ffff, FLASH_RESERVED,
                     16'd1234, 16'd5678);
        post_request(rgbled_pkg::FUNC_NOTIFICATION, 32'hff00_0000, rgbled_pkg::FLASH_TIMED,
                     16'd10, 16'd20);
        post_request(rgbled_pkg::FUNC_ATTENTION, 32'h7f00_0000, rgbled_pkg::FLASH_NONE,
                     16'd30, 16'd40);
        post_request(rgbled_pkg::FUNC_BATTERY, 32'hffff_ffff, rgbled_pkg::FLASH_NONE,
                     16'hffff, 16'hffff);
        post_request(rgbled_pkg::FUNC_BATTERY, 32'h0000_0000, rgbled_pkg::FLASH_HW,
                     16'hffff, 16'hffff);
        post_request(rgbled_pkg::FUNC_ATTENTION, 32'hff01_0101, rgbled_pkg::FLASH_HW,
                     16'hffff, 16'hffff);
        post_request(rgbled_pkg::FUNC_NOTIFICATION, 32'h01ff_ffff, rgbled_pkg::FLASH_NONE,
                     16'h8000, 16'h8000);
        post_request(rgbled_pkg::FUNC_NOTIFICATION, 32'hfe80_0000, rgbled_pkg::FLASH_TIMED,
                     16'h5555, 16'haaaa);

        settings[0] = 12'd4095;
        settings[1] = 12'd1;
        settings[2] = 12'd0;
        settings[3] = 12'd254;
        settings[4] = 12'd256;
        settings[5] = 12'($urandom_range(2, 4094));
        settings[6] = rgbled_pkg::BRIGHTNESS_RESET;
        settings[7] = 12'($urandom_range(2, 4094));

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            // every write waits for the pipeline to drain first
            set_panel_max(settings[ph]);
            idling_on = (ph != 3 && ph != NUM_PHASES - 1);
            post_request(rgbled_pkg::FUNC_BACKLIGHT, 32'h00ff_ffff, rgbled_pkg::FLASH_NONE,
                         16'h0000, 16'h0000);
            post_request(rgbled_pkg::FUNC_BACKLIGHT, 32'hff00_0000, rgbled_pkg::FLASH_NONE,
                         16'h0000, 16'h0000);
            post_request(rgbled_pkg::FUNC_BACKLIGHT, 32'h0001_0101, rgbled_pkg::FLASH_NONE,
                         16'h0000, 16'h0000);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                req_backlog = {req_backlog, random_request()};
            end
        end

        wait_until_idle();
        repeat (8) @(posedge clk);
        $display("Covered %0d backlight, %0d kept-kind and %0d unsupported requests,",
                 n_backlight, n_kept, n_unsupported);
        $display("%0d results checked over %0d panel maximum settings",
                 n_results, n_settings);
        if (errors == 0 && expected_rsp.size() == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timeout with %0d results outstanding", expected_rsp.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
